// ===== src/rbid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ring-buffer deque package
// Shared widths, operation and status codes, and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbid_pkg;

  // Default sizing of the element store.
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the channels.
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned FILL_W     = 5;

  // Operation requested by an input item.
  typedef enum logic [KIND_W-1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } kind_e;

  // Completion status returned with each result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic decode;     // register the range and capacity check
    logic setup;      // prepare the shift loop
    logic rd_target;  // read the entry at the requested position
    logic take;       // capture the old entry, write the new value for a set
    logic move;       // advance the shift loop by one entry
    logic commit;     // final write for an insert, head and count update
    logic emit;       // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;         // check failed, nothing changes
    logic is_insert;
    logic is_remove;
    logic moves_zero;  // no more reads to issue in the shift loop
    logic pending;     // a shifted entry still waits to be written
  } stat_t;

endpackage

// ===== src/rbid_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ring-buffer deque channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------

// Request channel: one operation per item.
interface rbid_in_if;
  logic                           valid;
  logic                           ready;
  logic [rbid_pkg::KIND_W-1:0]    kind;
  logic [rbid_pkg::POS_W-1:0]     position;
  logic [rbid_pkg::IN_DATA_W-1:0] data_in;

  modport source (output valid, output kind, output position, output data_in, input ready);
  modport sink   (input valid, input kind, input position, input data_in, output ready);
endinterface

// Result channel: one item per request.
interface rbid_out_if;
  logic                            valid;
  logic                            ready;
  logic [rbid_pkg::OUT_DATA_W-1:0] data_out;
  logic [rbid_pkg::STATUS_W-1:0]   status;
  logic [rbid_pkg::FILL_W-1:0]     fill;

  modport source (output valid, output data_out, output status, output fill, input ready);
  modport sink   (input valid, input data_out, input status, input fill, output ready);
endinterface

// ===== src/rbid_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ring-buffer deque datapath
// Element store, head and count registers, request checks, the one-entry-per-
// cycle shift loop and the output register.
// ----------------------------------------------------------------------------
module rbid_dpath #(
  parameter int unsigned CAPACITY   = rbid_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = rbid_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rbid_pkg::cmd_t                  cmd_i,
  output rbid_pkg::stat_t                 stat_o,
  input  logic [rbid_pkg::KIND_W-1:0]     kind_i,
  input  logic [rbid_pkg::POS_W-1:0]      position_i,
  input  logic [rbid_pkg::IN_DATA_W-1:0]  data_in_i,
  output logic [rbid_pkg::OUT_DATA_W-1:0] data_out_o,
  output logic [rbid_pkg::STATUS_W-1:0]   status_o,
  output logic [rbid_pkg::FILL_W-1:0]     fill_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned IDXP_W = IDX_W + 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > rbid_pkg::POS_W) ? CNT_W : rbid_pkg::POS_W;
  localparam int unsigned EXT_W  = DATA_WIDTH + rbid_pkg::IN_DATA_W;

  localparam logic [IDXP_W-1:0] CAP_X     = IDXP_W'(CAPACITY);
  localparam logic [CMP_W-1:0]  CAP_C     = CMP_W'(CAPACITY);
  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W-1:0]  ONE_IDX   = IDX_W'(1);

  // Physical slot of a logical offset from the given head slot.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] off);
    logic [IDXP_W-1:0] sum;
    sum = IDXP_W'(base) + IDXP_W'(off);
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  // Element store and its registered read port.
  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_q;

  // Control state.
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] moves_q, moves_d;

  // Item and loop payload.
  rbid_pkg::kind_e       kind_q;
  logic [rbid_pkg::POS_W-1:0] pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  rbid_pkg::status_e     status_q;
  logic [DATA_WIDTH-1:0] result_q;
  logic [IDX_W-1:0]      src_q, src_d;
  logic [IDX_W-1:0]      wr_off_q;
  logic                  asc_q, asc_d;

  // Output register payload.
  logic [rbid_pkg::OUT_DATA_W-1:0] data_out_q;
  rbid_pkg::status_e               out_status_q;
  logic [rbid_pkg::FILL_W-1:0]     fill_q;

  // Derived values.
  logic [CMP_W-1:0]  pos_x, n_x, moves_x;
  logic [IDX_W-1:0]  pos_off, tgt_slot, src_slot, wr_slot, dst_off;
  logic              front;
  rbid_pkg::status_e chk_status;
  logic [EXT_W-1:0]  in_ext, res_ext;

  // Memory port controls.
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  assign pos_x    = CMP_W'(pos_q);
  assign n_x      = CMP_W'(count_q);
  assign pos_off  = pos_x[IDX_W-1:0];
  assign front    = pos_x < (n_x >> 1);
  assign tgt_slot = slot_of(head_q, pos_off);
  assign src_slot = slot_of(head_q, src_q);
  assign wr_slot  = slot_of(head_q, wr_off_q);
  assign dst_off  = asc_q ? (src_q - ONE_IDX) : (src_q + ONE_IDX);
  assign in_ext   = EXT_W'(data_in_i);
  assign res_ext  = EXT_W'(result_q);

  // Range and capacity check of the held item.
  always_comb begin
    chk_status = rbid_pkg::ST_OK;
    case (kind_q)
      rbid_pkg::OP_GET, rbid_pkg::OP_SET: begin
        if (pos_x >= n_x) chk_status = rbid_pkg::ST_RANGE;
      end
      rbid_pkg::OP_INSERT: begin
        if (n_x == CAP_C) chk_status = rbid_pkg::ST_FULL;
        else if (pos_x > n_x) chk_status = rbid_pkg::ST_RANGE;
      end
      rbid_pkg::OP_REMOVE: begin
        if (n_x == '0) chk_status = rbid_pkg::ST_EMPTY;
        else if (pos_x >= n_x) chk_status = rbid_pkg::ST_RANGE;
      end
      default: chk_status = rbid_pkg::ST_OK;
    endcase
  end

  assign stat_o.err        = (chk_status != rbid_pkg::ST_OK);
  assign stat_o.is_insert  = (kind_q == rbid_pkg::OP_INSERT);
  assign stat_o.is_remove  = (kind_q == rbid_pkg::OP_REMOVE);
  assign stat_o.moves_zero = (moves_q == '0);
  assign stat_o.pending    = pend_q;

  // Shift loop plan, head, count and loop registers.
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pend_d  = pend_q;
    moves_d = moves_q;
    src_d   = src_q;
    asc_d   = asc_q;
    moves_x = '0;
    if (cmd_i.setup) begin
      pend_d = 1'b0;
      if (kind_q == rbid_pkg::OP_INSERT) begin
        if (front) begin
          // The front side moves toward the new head one slot back.
          moves_x = pos_x;
          src_d   = ONE_IDX;
          asc_d   = 1'b1;
          head_d  = (head_q == '0) ? LAST_SLOT : (head_q - ONE_IDX);
        end else begin
          moves_x = n_x - pos_x;
          src_d   = n_x[IDX_W-1:0] - ONE_IDX;
          asc_d   = 1'b0;
        end
      end else begin
        if (front) begin
          moves_x = pos_x;
          src_d   = pos_off - ONE_IDX;
          asc_d   = 1'b0;
        end else begin
          moves_x = n_x - pos_x - CMP_W'(1);
          src_d   = pos_off + ONE_IDX;
          asc_d   = 1'b1;
        end
      end
      moves_d = moves_x[CNT_W-1:0];
    end else if (cmd_i.move) begin
      // Issue one read per cycle; its write follows in the next cycle.
      pend_d = (moves_q != '0);
      if (moves_q != '0) begin
        moves_d = moves_q - CNT_W'(1);
        src_d   = asc_q ? (src_q + ONE_IDX) : (src_q - ONE_IDX);
      end
    end
    if (cmd_i.commit) begin
      if (kind_q == rbid_pkg::OP_INSERT) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        count_d = count_q - CNT_W'(1);
        if (front) head_d = slot_of(head_q, ONE_IDX);
      end
    end
  end

  // Store port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tgt_slot;
    mem_wdata = val_q;
    mem_re    = 1'b0;
    mem_raddr = tgt_slot;
    if (cmd_i.take && kind_q == rbid_pkg::OP_SET) begin
      mem_we = 1'b1;
    end else if (cmd_i.move && pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_slot;
      mem_wdata = rd_data_q;
    end else if (cmd_i.commit && kind_q == rbid_pkg::OP_INSERT) begin
      mem_we = 1'b1;
    end
    if (cmd_i.rd_target) begin
      mem_re = 1'b1;
    end else if (cmd_i.move && moves_q != '0) begin
      mem_re    = 1'b1;
      mem_raddr = src_slot;
    end
  end

  // Element store.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem_q[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
      moves_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      moves_q <= moves_d;
    end
  end

  // Item, loop and output payload registers.
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    asc_q <= asc_d;
    if (cmd_i.move && moves_q != '0) wr_off_q <= dst_off;
    if (cmd_i.load) begin
      kind_q   <= rbid_pkg::kind_e'(kind_i);
      pos_q    <= position_i;
      val_q    <= in_ext[DATA_WIDTH-1:0];
      result_q <= '0;
    end
    if (cmd_i.decode) status_q <= chk_status;
    if (cmd_i.take) result_q <= rd_data_q;
    if (cmd_i.emit) begin
      data_out_q   <= res_ext[rbid_pkg::OUT_DATA_W-1:0];
      out_status_q <= status_q;
      fill_q       <= rbid_pkg::FILL_W'(count_q);
    end
  end

  assign data_out_o = data_out_q;
  assign status_o   = out_status_q;
  assign fill_o     = fill_q;

endmodule

// ===== src/rbid_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ring-buffer deque controller
// Sequences one item at a time through check, target access, shift loop and
// result hand-off, and owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
module rbid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rbid_pkg::stat_t stat_i,
  output rbid_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_TAKE,
    S_MOVE,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   loop_done;

  assign loop_done = stat_i.moves_zero && !stat_i.pending;

  // Command decode of the current state.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        cmd_o.setup  = !stat_i.err && stat_i.is_insert;
      end
      S_READ:   cmd_o.rd_target = 1'b1;
      S_TAKE:   begin
        cmd_o.take  = 1'b1;
        cmd_o.setup = stat_i.is_remove;
      end
      S_MOVE:   begin
        cmd_o.move   = 1'b1;
        cmd_o.commit = loop_done;
      end
      S_DONE:   cmd_o.emit = !out_valid_q || out_ready_i;
      default:  cmd_o = '0;
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECODE;
        end
        S_DECODE: begin
          if (stat_i.err) state_q <= S_DONE;
          else if (stat_i.is_insert) state_q <= S_MOVE;
          else state_q <= S_READ;
        end
        S_READ: state_q <= S_TAKE;
        S_TAKE: begin
          if (stat_i.is_remove) state_q <= S_MOVE;
          else state_q <= S_DONE;
        end
        S_MOVE: begin
          if (loop_done) state_q <= S_DONE;
        end
        S_DONE: begin
          if (cmd_o.emit) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/ring_buffer_indexed_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ring-buffer deque
// Fixed-capacity circular deque with get, set, insert and remove at an index.
// Insert and remove shift the entries between the position and the nearer end,
// at most CAPACITY/2 of them, at one per cycle; a failed check goes straight
// to the result with no store access.
// Throughput: one item at a time; the next item can be taken in the cycle after
// the result enters the output register. Reset clears head, count and handshake.
// ----------------------------------------------------------------------------
module ring_buffer_indexed_deque #(
  parameter int unsigned CAPACITY   = rbid_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = rbid_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbid_in_if.sink     in_i,
  rbid_out_if.source  out_o
);

  rbid_pkg::cmd_t  cmd;
  rbid_pkg::stat_t stat;

  // Sequencer.
  rbid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Store and arithmetic.
  rbid_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .kind_i     (in_i.kind),
    .position_i (in_i.position),
    .data_in_i  (in_i.data_in),
    .data_out_o (out_o.data_out),
    .status_o   (out_o.status),
    .fill_o     (out_o.fill)
  );

  // Only one item is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item accepted while another is in flight");

  // A full report comes only with a full store.
  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == rbid_pkg::ST_FULL) |->
      (out_o.fill == rbid_pkg::FILL_W'(CAPACITY)))
    else $error("full status with a store that is not full");

  // An empty report comes only with an empty store.
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == rbid_pkg::ST_EMPTY) |-> (out_o.fill == '0))
    else $error("empty status with a store that is not empty");

  // The shift loop never writes before a read was issued to feed it.
  a_loop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.pending && cmd.move) |-> $past(cmd.move))
    else $error("shift write without a preceding read");

endmodule

// ===== test/ring_buffer_indexed_deque_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ring-buffer deque testbench
// Drives get, set, insert and remove requests through the request channel
// and checks every result item against an in-bench model of the deque: the
// circular store, the head slot and the element count. The stimulus is a
// short directed list of corner cases followed by random phases that grow,
// shrink or churn the deque. Both channels idle at random, and the result
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module ring_buffer_indexed_deque_test;

  localparam int unsigned CAP          = rbid_pkg::CAPACITY_DEF;
  localparam int unsigned HEAD_W       = $clog2(rbid_pkg::CAPACITY_DEF);
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned PRESSURE_AT  = 300;
  localparam int unsigned PRESSURE_LEN = 250;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    rbid_pkg::kind_e                kind;
    logic [rbid_pkg::POS_W-1:0]     position;
    logic [rbid_pkg::IN_DATA_W-1:0] data_in;
  } request_t;

  typedef struct packed {
    logic [rbid_pkg::OUT_DATA_W-1:0] data_out;
    rbid_pkg::status_e               status;
    logic [rbid_pkg::FILL_W-1:0]     fill;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rbid_in_if  in_if ();
  rbid_out_if out_if ();

  ring_buffer_indexed_deque dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Model state of the deque.
  logic [rbid_pkg::DATA_WIDTH_DEF-1:0] ring_mem [CAP];
  logic [HEAD_W-1:0]                   ring_head;
  logic [rbid_pkg::FILL_W-1:0]         ring_fill;

  // Request and reply bookkeeping.
  request_t    requests_to_send[$];
  reply_t      replies_due[$];
  int unsigned reqs_generated;
  int unsigned reqs_offered;
  int unsigned reqs_taken;
  int unsigned gen_fill;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Idle control of both channels.
  int unsigned send_gap;
  bit          send_calm;
  int unsigned hold_left;
  bit          recv_calm;
  bit          pressure_done;

  request_t seen_req;
  reply_t   seen_reply;
  request_t next_req;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Physical slot of a logical offset from the head.
  function automatic logic [HEAD_W-1:0] ring_slot(int unsigned offset);
    return HEAD_W'((int'(ring_head) + offset) % CAP);
  endfunction

  // Apply one request to the model deque and return the reply it owes.
  function automatic reply_t deque_apply(request_t req);
    reply_t      rep;
    int unsigned pos;
    int unsigned n;
    int unsigned k;
    rep.data_out = '0;
    rep.status   = rbid_pkg::ST_OK;
    pos          = int'(req.position);
    n            = int'(ring_fill);
    case (req.kind)
      rbid_pkg::OP_GET, rbid_pkg::OP_SET: begin
        if (pos >= n) begin
          rep.status = rbid_pkg::ST_RANGE;
        end else begin
          rep.data_out = ring_mem[ring_slot(pos)];
          if (req.kind == rbid_pkg::OP_SET) begin
            ring_mem[ring_slot(pos)] = req.data_in;
          end
        end
      end
      rbid_pkg::OP_INSERT: begin
        if (n >= CAP) begin
          rep.status = rbid_pkg::ST_FULL;
        end else if (pos > n) begin
          rep.status = rbid_pkg::ST_RANGE;
        end else begin
          // The shorter side moves; the front side drags the head back.
          if (pos < n / 2) begin
            ring_head = HEAD_W'((int'(ring_head) + CAP - 1) % CAP);
            for (k = 0; k < pos; k++) begin
              ring_mem[ring_slot(k)] = ring_mem[ring_slot(k + 1)];
            end
          end else begin
            for (k = n; k > pos; k--) begin
              ring_mem[ring_slot(k)] = ring_mem[ring_slot(k - 1)];
            end
          end
          ring_mem[ring_slot(pos)] = req.data_in;
          ring_fill = rbid_pkg::FILL_W'(n + 1);
        end
      end
      default: begin
        if (n == 0) begin
          rep.status = rbid_pkg::ST_EMPTY;
        end else if (pos >= n) begin
          rep.status = rbid_pkg::ST_RANGE;
        end else begin
          rep.data_out = ring_mem[ring_slot(pos)];
          // Closing the gap from the front pushes the head forward.
          if (pos < n / 2) begin
            for (k = pos; k > 0; k--) begin
              ring_mem[ring_slot(k)] = ring_mem[ring_slot(k - 1)];
            end
            ring_head = ring_slot(1);
          end else begin
            for (k = pos; k + 1 < n; k++) begin
              ring_mem[ring_slot(k)] = ring_mem[ring_slot(k + 1)];
            end
          end
          ring_fill = rbid_pkg::FILL_W'(n - 1);
        end
      end
    endcase
    rep.fill = ring_fill;
    return rep;
  endfunction

  // Idle length: mostly none, often short, sometimes long.
  function automatic int unsigned draw_gap(int unsigned idle_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r >= idle_pct) return 0;
    if (r < idle_pct * 3 / 4) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Queue a request and track the fill it leaves behind.
  task automatic queue_request(rbid_pkg::kind_e kind, int unsigned pos,
                               logic [rbid_pkg::IN_DATA_W-1:0] data);
    request_t req;
    req.kind     = kind;
    req.position = rbid_pkg::POS_W'(pos);
    req.data_in  = data;
    requests_to_send.push_back(req);
    reqs_generated++;
    if (kind == rbid_pkg::OP_INSERT && gen_fill < CAP && pos <= gen_fill) begin
      gen_fill++;
    end else if (kind == rbid_pkg::OP_REMOVE && gen_fill > 0 && pos < gen_fill) begin
      gen_fill--;
    end
  endtask

  // Mostly legal positions, some beyond the held range up to the field maximum.
  function automatic int unsigned pick_position(rbid_pkg::kind_e kind);
    int unsigned span;
    span = (kind == rbid_pkg::OP_INSERT) ? gen_fill + 1 : gen_fill;
    if (span > 0 && $urandom_range(99) < 90) return $urandom_range(span - 1, 0);
    return $urandom_range((1 << rbid_pkg::POS_W) - 1, span);
  endfunction

  function automatic logic [rbid_pkg::IN_DATA_W-1:0] pick_data();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mismatch report: one line per failure.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Request driver: present the next item once the previous one was taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (reqs_taken == reqs_offered) begin
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (requests_to_send.size() > 0) begin
        next_req       = requests_to_send.pop_front();
        in_if.kind     <= next_req.kind;
        in_if.position <= next_req.position;
        in_if.data_in  <= next_req.data_in;
        in_if.valid    <= 1'b1;
        reqs_offered   <= reqs_offered + 1;
        send_gap       <= send_calm ? 0 : draw_gap(45);
        if ($urandom_range(63) == 0) begin
          send_calm <= !send_calm;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, one long hold-off to back up the block.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!pressure_done && reqs_taken >= PRESSURE_AT) begin
      pressure_done <= 1'b1;
      hold_left     <= PRESSURE_LEN;
      out_if.ready  <= 1'b0;
    end else begin
      if (recv_calm) begin
        out_if.ready <= 1'b1;
      end else begin
        hold_left    <= draw_gap(30);
        out_if.ready <= 1'b1;
      end
      if ($urandom_range(99) == 0) begin
        recv_calm <= !recv_calm;
      end
    end
  end

  // Sample both channels: predict on acceptance, check on delivery.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        seen_req.kind     = rbid_pkg::kind_e'(in_if.kind);
        seen_req.position = in_if.position;
        seen_req.data_in  = in_if.data_in;
        replies_due.push_back(deque_apply(seen_req));
        reqs_taken <= reqs_taken + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unrequested result", out_if.data_out, '0);
        end else begin
          seen_reply = replies_due.pop_front();
          if (out_if.data_out !== seen_reply.data_out) begin
            report_mismatch("data_out", out_if.data_out, seen_reply.data_out);
          end
          if (out_if.status !== seen_reply.status) begin
            report_mismatch("status", 32'(out_if.status), 32'(seen_reply.status));
          end
          if (out_if.fill !== seen_reply.fill) begin
            report_mismatch("fill", 32'(out_if.fill), 32'(seen_reply.fill));
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL ring_buffer_indexed_deque");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned     phase;
    int unsigned     phase_len;
    int unsigned     r;
    rbid_pkg::kind_e kind;

    in_if.valid    = 1'b0;
    in_if.kind     = rbid_pkg::OP_GET;
    in_if.position = '0;
    in_if.data_in  = '0;
    out_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    ring_head      = '0;
    ring_fill      = '0;
    reqs_generated = 0;
    reqs_offered   = 0;
    reqs_taken     = 0;
    gen_fill       = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_gap       = 0;
    send_calm      = 1'b0;
    hold_left      = 0;
    recv_calm      = 1'b0;
    pressure_done  = 1'b0;
    ring_mem       = '{default: '0};

    // Directed: empty-deque errors, front and back shifts, range checks.
    queue_request(rbid_pkg::OP_GET, 0, 32'h0);
    queue_request(rbid_pkg::OP_SET, 0, 32'hDEADBEEF);
    queue_request(rbid_pkg::OP_REMOVE, 0, 32'h0);
    queue_request(rbid_pkg::OP_INSERT, 1, 32'h11111111);
    queue_request(rbid_pkg::OP_INSERT, 31, 32'h22222222);
    queue_request(rbid_pkg::OP_INSERT, 0, 32'h00000000);
    queue_request(rbid_pkg::OP_INSERT, 1, 32'hFFFFFFFF);
    queue_request(rbid_pkg::OP_INSERT, 0, 32'hA5A5A5A5);
    queue_request(rbid_pkg::OP_INSERT, 2, 32'h5A5A5A5A);
    for (int i = 0; i < 5; i++) begin
      queue_request(rbid_pkg::OP_GET, i, 32'h0);
    end
    queue_request(rbid_pkg::OP_SET, 3, 32'h12345678);
    queue_request(rbid_pkg::OP_SET, 31, 32'hFFFFFFFF);
    queue_request(rbid_pkg::OP_REMOVE, 31, 32'h0);
    queue_request(rbid_pkg::OP_REMOVE, 3, 32'h0);
    queue_request(rbid_pkg::OP_REMOVE, 0, 32'h0);
    queue_request(rbid_pkg::OP_REMOVE, 1, 32'h0);
    queue_request(rbid_pkg::OP_REMOVE, 0, 32'h0);
    queue_request(rbid_pkg::OP_REMOVE, 0, 32'h0);

    // Random phases: grow toward full, shrink toward empty, or churn.
    while (reqs_generated < RANDOM_ITEMS + 22) begin
      phase     = $urandom_range(2);
      phase_len = $urandom_range(40, 8);
      repeat (phase_len) begin
        r = $urandom_range(99);
        case (phase)
          0:       kind = (r < 60) ? rbid_pkg::OP_INSERT : (r < 72) ? rbid_pkg::OP_REMOVE :
                          (r < 86) ? rbid_pkg::OP_GET : rbid_pkg::OP_SET;
          1:       kind = (r < 15) ? rbid_pkg::OP_INSERT : (r < 75) ? rbid_pkg::OP_REMOVE :
                          (r < 88) ? rbid_pkg::OP_GET : rbid_pkg::OP_SET;
          default: kind = rbid_pkg::kind_e'(r % 4);
        endcase
        queue_request(kind, pick_position(kind), pick_data());
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (reqs_taken < reqs_generated || replies_due.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS ring_buffer_indexed_deque");
    end else begin
      $display("FAIL ring_buffer_indexed_deque");
    end
    $finish;
  end

endmodule
